FILE: rtl/core/gds_pkg.sv
// package: word types and fixed constants of the gaze direction smoother
`default_nettype none
package gds_pkg;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] origin_z;
    logic        [15:0] confidence_in;
    logic               left_blink;
    logic               right_blink;
    logic               device_connected;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_origin_x;
    logic signed [15:0] out_origin_y;
    logic signed [15:0] out_origin_z;
    logic signed [15:0] smooth_x;
    logic signed [15:0] smooth_y;
    logic signed [15:0] smooth_z;
    logic        [15:0] out_confidence;
    logic               gaze_valid;
    logic               left_blinking;
    logic               right_blinking;
    logic               eyes_closed;
    logic               connected;
  } out_word_t;

  localparam int unsigned RAD_W      = 62;
  localparam int unsigned ROOT_W     = 31;
  localparam int unsigned REM_W      = 33;
  localparam int unsigned M_W        = 31;
  localparam int unsigned FRAC_W     = 14;
  localparam int unsigned NUM_W      = 46;
  localparam int unsigned QUO_W      = 15;
  localparam int unsigned SQRT_STEPS = 31;

  localparam logic [QUO_W-1:0] UNIT_LEN = 15'd16384;

  localparam logic REG_WLEN   = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  localparam logic [4:0]  WLEN_RESET   = 5'd5;
  localparam logic [15:0] THRESH_RESET = 16'd32768;

endpackage
`default_nettype wire

FILE: rtl/core/gds_ram.sv
// generic single-write, registered-read ram
`default_nettype none
module gds_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/core/gaze_direction_smoother_core.sv
// top level: sliding-window gaze direction smoother with bit-serial normalize
// a right-blink word goes straight to the result state and repeats the held outputs;
// other words pass through update, serial squaring of SUM_W = 17 + clog2(WINDOW_MAX)
// bits, up to 30 2-bit normalize shifts, 31 root digits and 15 quotient bits
// one word in flight; the output register lets the next word enter while a result waits
// reset clears window count, sums, held outputs and state; window ram is not cleared
`default_nettype none
module gaze_direction_smoother_core #(
  parameter int unsigned WINDOW_MAX = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire gds_pkg::in_word_t in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output gds_pkg::out_word_t     out_word_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int unsigned SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SW     = CNT_W + 1;
  localparam int unsigned SUM_W  = 17 + $clog2(WINDOW_MAX);
  localparam int unsigned MAG_W  = SUM_W;
  localparam int unsigned SQ_W   = 2 * MAG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_SQI, S_SQ, S_LEN, S_NRM, S_SQRT, S_DIVI, S_DIV, S_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  gds_pkg::out_word_t out_q;

  logic [4:0]  wlen_q;
  logic [15:0] thresh_q;
  logic [CNT_W-1:0]  count_q;
  logic [SLOT_W-1:0] oldest_q;
  logic signed [SUM_W-1:0] sum_q [3];
  logic signed [15:0] held_origin_q [3];
  logic signed [15:0] held_dir_q [3];
  logic [15:0] held_conf_q;
  logic        held_valid_q;

  gds_pkg::in_word_t in_q;
  logic [SLOT_W-1:0] slot_q;
  logic              full_q;
  logic              zero_q;
  logic [4:0]        step_q;
  logic              sign_q [3];
  logic [MAG_W-1:0]  mag_q [3];
  logic [SQ_W-1:0]   mcand_q [3];
  logic [MAG_W-1:0]  mplier_q [3];
  logic [SQ_W-1:0]   acc_q [3];
  logic [gds_pkg::M_W-1:0]    m_q [3];
  logic [gds_pkg::RAD_W-1:0]  rad_q;
  logic [gds_pkg::REM_W-1:0]  rem_q;
  logic [gds_pkg::ROOT_W-1:0] root_q;
  logic [gds_pkg::NUM_W-1:0]  num_q [3];
  logic [gds_pkg::ROOT_W-1:0] r_q [3];
  logic [gds_pkg::QUO_W-1:0]  quo_q [3];

  logic in_acc, out_free, cfg_wr;
  logic [CNT_W-1:0]  len_eff;
  logic [SW-1:0]     slot_sum;
  logic [SLOT_W-1:0] slot_new, oldest_next;
  logic [47:0]       ram_rdata;
  logic signed [15:0] new_dir [3];
  logic signed [15:0] old_dir [3];
  logic signed [SUM_W-1:0] sum_d [3];
  logic [gds_pkg::RAD_W-1:0]  len2;
  logic [gds_pkg::REM_W+1:0]  rem_sh, trial;
  logic [gds_pkg::NUM_W-1:0]  num_w [3];
  logic [gds_pkg::ROOT_W:0]   r_sh [3];
  logic [gds_pkg::QUO_W-1:0]  q_cap [3];
  logic signed [15:0] fin_dir [3];
  gds_pkg::out_word_t fin_word;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      gds_pkg::REG_WLEN:   prdata = {27'd0, wlen_q};
      gds_pkg::REG_THRESH: prdata = {16'd0, thresh_q};
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    if (wlen_q == 5'd0) begin
      len_eff = CNT_W'(1);
    end else if (32'(wlen_q) > WINDOW_MAX) begin
      len_eff = CNT_W'(WINDOW_MAX);
    end else begin
      len_eff = CNT_W'(wlen_q);
    end
    slot_sum = SW'(oldest_q) + SW'(count_q);
    if (slot_sum >= SW'(WINDOW_MAX)) begin
      slot_new = SLOT_W'(slot_sum - SW'(WINDOW_MAX));
    end else begin
      slot_new = SLOT_W'(slot_sum);
    end
    if (32'(oldest_q) + 32'd1 >= WINDOW_MAX) begin
      oldest_next = '0;
    end else begin
      oldest_next = oldest_q + SLOT_W'(1);
    end
  end

  gds_ram #(
    .WIDTH(48),
    .DEPTH(WINDOW_MAX)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (state_q == S_UPD),
    .waddr_i(slot_q),
    .wdata_i({in_q.dir_x, in_q.dir_y, in_q.dir_z}),
    .raddr_i(oldest_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    new_dir[0] = in_q.dir_x;
    new_dir[1] = in_q.dir_y;
    new_dir[2] = in_q.dir_z;
    old_dir[0] = ram_rdata[47:32];
    old_dir[1] = ram_rdata[31:16];
    old_dir[2] = ram_rdata[15:0];
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = sum_q[i] - (full_q ? SUM_W'(old_dir[i]) : SUM_W'(0)) + SUM_W'(new_dir[i]);
    end
    len2   = gds_pkg::RAD_W'(acc_q[0]) + gds_pkg::RAD_W'(acc_q[1])
           + gds_pkg::RAD_W'(acc_q[2]);
    rem_sh = {rem_q, rad_q[gds_pkg::RAD_W-1 -: 2]};
    trial  = (gds_pkg::REM_W+2)'({root_q, 2'b01});
    for (int i = 0; i < 3; i++) begin
      num_w[i] = {m_q[i], gds_pkg::FRAC_W'(0)} + gds_pkg::NUM_W'(root_q >> 1);
      r_sh[i]  = {r_q[i], num_q[i][gds_pkg::QUO_W-1]};
      q_cap[i] = (quo_q[i] > gds_pkg::UNIT_LEN) ? gds_pkg::UNIT_LEN : quo_q[i];
      if (zero_q) begin
        fin_dir[i] = '0;
      end else if (sign_q[i]) begin
        fin_dir[i] = -16'(q_cap[i]);
      end else begin
        fin_dir[i] = 16'(q_cap[i]);
      end
    end
  end

  always_comb begin
    fin_word.left_blinking  = in_q.left_blink;
    fin_word.right_blinking = in_q.right_blink;
    fin_word.eyes_closed    = in_q.right_blink && in_q.left_blink;
    fin_word.connected      = in_q.device_connected;
    if (in_q.right_blink) begin
      fin_word.out_origin_x   = held_origin_q[0];
      fin_word.out_origin_y   = held_origin_q[1];
      fin_word.out_origin_z   = held_origin_q[2];
      fin_word.smooth_x       = held_dir_q[0];
      fin_word.smooth_y       = held_dir_q[1];
      fin_word.smooth_z       = held_dir_q[2];
      fin_word.out_confidence = held_conf_q;
      fin_word.gaze_valid     = held_valid_q;
    end else begin
      fin_word.out_origin_x   = in_q.origin_x;
      fin_word.out_origin_y   = in_q.origin_y;
      fin_word.out_origin_z   = in_q.origin_z;
      fin_word.smooth_x       = fin_dir[0];
      fin_word.smooth_y       = fin_dir[1];
      fin_word.smooth_z       = fin_dir[2];
      fin_word.out_confidence = in_q.confidence_in;
      fin_word.gaze_valid     = (in_q.confidence_in >= thresh_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      wlen_q       <= gds_pkg::WLEN_RESET;
      thresh_q     <= gds_pkg::THRESH_RESET;
      count_q      <= '0;
      oldest_q     <= '0;
      held_conf_q  <= '0;
      held_valid_q <= 1'b0;
      step_q       <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i]         <= '0;
        held_origin_q[i] <= '0;
        held_dir_q[i]    <= '0;
      end
    end else begin
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (paddr[2])
          gds_pkg::REG_WLEN: begin
            wlen_q   <= pwdata[4:0];
            count_q  <= '0;
            oldest_q <= '0;
            for (int i = 0; i < 3; i++) sum_q[i] <= '0;
          end
          gds_pkg::REG_THRESH: thresh_q <= pwdata[15:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= in_word_i.right_blink ? S_FIN : S_UPD;
          end
        end
        S_UPD: begin
          for (int i = 0; i < 3; i++) sum_q[i] <= sum_d[i];
          if (full_q) begin
            oldest_q <= oldest_next;
          end else begin
            count_q <= count_q + CNT_W'(1);
          end
          state_q <= S_SQI;
        end
        S_SQI: begin
          step_q  <= '0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'(MAG_W - 1)) state_q <= S_LEN;
        end
        S_LEN: state_q <= (len2 == '0) ? S_FIN : S_NRM;
        S_NRM: begin
          step_q <= '0;
          if (rad_q[gds_pkg::RAD_W-1 -: 2] != 2'b00) state_q <= S_SQRT;
        end
        S_SQRT: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'(gds_pkg::SQRT_STEPS - 1)) state_q <= S_DIVI;
        end
        S_DIVI: begin
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'(gds_pkg::QUO_W - 1)) state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_q       <= fin_word;
            state_q     <= S_IDLE;
            if (!in_q.right_blink) begin
              held_origin_q[0] <= fin_word.out_origin_x;
              held_origin_q[1] <= fin_word.out_origin_y;
              held_origin_q[2] <= fin_word.out_origin_z;
              held_dir_q[0]    <= fin_word.smooth_x;
              held_dir_q[1]    <= fin_word.smooth_y;
              held_dir_q[2]    <= fin_word.smooth_z;
              held_conf_q      <= fin_word.out_confidence;
              held_valid_q     <= fin_word.gaze_valid;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q   <= in_word_i;
      slot_q <= (count_q >= len_eff) ? oldest_q : slot_new;
      full_q <= (count_q >= len_eff);
    end
    unique case (state_q)
      S_SQI: begin
        for (int i = 0; i < 3; i++) begin
          sign_q[i]   <= sum_q[i][SUM_W-1];
          mag_q[i]    <= sum_q[i][SUM_W-1] ? MAG_W'(-sum_q[i]) : MAG_W'(sum_q[i]);
          mcand_q[i]  <= SQ_W'(sum_q[i][SUM_W-1] ? MAG_W'(-sum_q[i]) : MAG_W'(sum_q[i]));
          mplier_q[i] <= sum_q[i][SUM_W-1] ? MAG_W'(-sum_q[i]) : MAG_W'(sum_q[i]);
          acc_q[i]    <= '0;
        end
      end
      S_SQ: begin
        for (int i = 0; i < 3; i++) begin
          if (mplier_q[i][0]) acc_q[i] <= acc_q[i] + mcand_q[i];
          mcand_q[i]  <= mcand_q[i] << 1;
          mplier_q[i] <= mplier_q[i] >> 1;
        end
      end
      S_LEN: begin
        rad_q  <= len2;
        zero_q <= (len2 == '0);
        rem_q  <= '0;
        root_q <= '0;
        for (int i = 0; i < 3; i++) m_q[i] <= gds_pkg::M_W'(mag_q[i]);
      end
      S_NRM: begin
        if (rad_q[gds_pkg::RAD_W-1 -: 2] == 2'b00) begin
          rad_q <= rad_q << 2;
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
        end
      end
      S_SQRT: begin
        rad_q <= rad_q << 2;
        if (rem_sh >= trial) begin
          rem_q  <= gds_pkg::REM_W'(rem_sh - trial);
          root_q <= {root_q[gds_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= gds_pkg::REM_W'(rem_sh);
          root_q <= {root_q[gds_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      S_DIVI: begin
        for (int i = 0; i < 3; i++) begin
          num_q[i] <= num_w[i];
          r_q[i]   <= num_w[i][gds_pkg::NUM_W-1 -: gds_pkg::ROOT_W];
          quo_q[i] <= '0;
        end
      end
      S_DIV: begin
        for (int i = 0; i < 3; i++) begin
          num_q[i] <= num_q[i] << 1;
          if (r_sh[i] >= {1'b0, root_q}) begin
            r_q[i]   <= gds_pkg::ROOT_W'(r_sh[i] - {1'b0, root_q});
            quo_q[i] <= {quo_q[i][gds_pkg::QUO_W-2:0], 1'b1};
          end else begin
            r_q[i]   <= gds_pkg::ROOT_W'(r_sh[i]);
            quo_q[i] <= {quo_q[i][gds_pkg::QUO_W-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= len_eff)
    else $error("window count above effective length");

  a_blink_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.right_blink |=> state_q == S_FIN)
    else $error("blink word did not go straight to result");

  a_root_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIVI |-> root_q[gds_pkg::ROOT_W-1])
    else $error("root not normalized before divide");

endmodule
`default_nettype wire
